[design/uv_sphere_vertex_generator_defines.svh]
// Assertion macros shared by the sphere vertex generator.
// Depends on nothing; included by the top level only.
`ifndef UV_SPHERE_VERTEX_GENERATOR_DEFINES_SVH
`define UV_SPHERE_VERTEX_GENERATOR_DEFINES_SVH
// Checks a property on every clock edge outside reset.
`define UVS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checks that a condition implies another one in the next cycle.
`define UVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

[design/uvs_pkg.sv]
// Package of the sphere vertex generator: widths, CORDIC constants and types.
// Depends on nothing.
package uvs_pkg;
  localparam int AngleBitsDef = 16;
  localparam int CoordFracDef = 8;
  localparam int CordicSteps = 28;
  localparam logic signed [33:0] CordicInit = 34'sd652032874;
  localparam int CoordLimit = 65535;
  localparam logic [1:0] CfgRadius = 2'd0;
  localparam logic [1:0] CfgSlices = 2'd1;
  localparam logic [1:0] CfgStacks = 2'd2;

  function automatic logic signed [33:0] atan_turn(input int i);
    logic signed [33:0] t;
    case (i)
      0: t = 34'sd536870912;  1: t = 34'sd316933406;  2: t = 34'sd167458907;
      3: t = 34'sd85004756;   4: t = 34'sd42667331;   5: t = 34'sd21354465;
      6: t = 34'sd10679838;   7: t = 34'sd5340245;    8: t = 34'sd2670163;
      9: t = 34'sd1335087;    10: t = 34'sd667544;    11: t = 34'sd333772;
      12: t = 34'sd166886;    13: t = 34'sd83443;     14: t = 34'sd41722;
      15: t = 34'sd20861;     16: t = 34'sd10430;     17: t = 34'sd5215;
      18: t = 34'sd2608;      19: t = 34'sd1304;      20: t = 34'sd652;
      21: t = 34'sd326;       22: t = 34'sd163;       23: t = 34'sd81;
      24: t = 34'sd41;        25: t = 34'sd20;        26: t = 34'sd10;
      27: t = 34'sd5;
      default: t = '0;
    endcase
    return t;
  endfunction

  typedef struct packed {
    logic        err;
    logic        quad;
    logic [15:0] f;
    logic [15:0] s;
    logic [15:0] radius;
  } side_t;
endpackage

[design/uv_sphere_vertex_generator.sv]
// Streams UV sphere vertices: each accepted (stack_pos, slice_pos) item yields one result
// with Q8.8 coordinates, quad triangle indices and a range flag. The block is one
// stall-together pipeline that accepts an item every cycle while the output register
// holds no untaken item; an item passes the pipelined restoring angle dividers, the
// 28-step CORDIC pipelines and the scaling stages in that order.
// Depends on uvs_pkg and the defines header.
`include "uv_sphere_vertex_generator_defines.svh"
module uv_sphere_vertex_generator import uvs_pkg::*; #(
  parameter int ANGLE_BITS = AngleBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         stack_pos_i,
  input  logic [7:0]         slice_pos_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [16:0] coord_x_o,
  output logic signed [16:0] coord_y_o,
  output logic signed [16:0] coord_z_o,
  output logic               quad_valid_o,
  output logic [15:0]        tri_a_first_o,
  output logic [15:0]        tri_a_second_o,
  output logic [15:0]        tri_a_third_o,
  output logic [15:0]        tri_b_first_o,
  output logic [15:0]        tri_b_second_o,
  output logic [15:0]        tri_b_third_o,
  output logic               range_error_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  localparam int NumBits = ANGLE_BITS + 10;
  localparam int CorLat = CordicSteps + 1;

  logic [15:0] radius_q;
  logic [7:0]  slices_q, stacks_q;
  logic        en;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 16'd256;
      slices_q <= 8'd16;
      stacks_q <= 8'd16;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgRadius: radius_q <= cfg_data_i;
        CfgSlices: slices_q <= cfg_data_i[7:0];
        CfgStacks: stacks_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline advances unless the output register holds an untaken item.
  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Front stage: range check, index math and divider operands.
  logic        err_d, quad_d;
  logic [16:0] f_full;
  side_t       side_d;
  logic [NumBits-1:0] pnum, anum;
  logic [8:0]  pden, aden;
  always_comb begin
    err_d  = (stacks_q == 8'd0) || (slices_q == 8'd0) ||
             (stack_pos_i > stacks_q) || (slice_pos_i > slices_q);
    quad_d = !err_d && (stack_pos_i < stacks_q) && (slice_pos_i < slices_q);
    f_full = 17'(stack_pos_i) * ({9'd0, slices_q} + 17'd1) + 17'(slice_pos_i);
    side_d.err    = err_d;
    side_d.quad   = quad_d;
    side_d.f      = f_full[15:0];
    side_d.s      = 16'(f_full + 17'(slices_q) + 17'd1);
    side_d.radius = radius_q;
    pnum = NumBits'({stack_pos_i, {ANGLE_BITS{1'b0}}}) + NumBits'(stacks_q);
    anum = NumBits'({slice_pos_i, {(ANGLE_BITS+1){1'b0}}}) + NumBits'(slices_q);
    pden = {stacks_q, 1'b0};
    aden = {slices_q, 1'b0};
  end

  logic               pv, av;
  logic [NumBits-1:0] pq, aq;
  logic [$bits(side_t)-1:0] side_div;
  logic               av_tag;

  uvs_divider #(.NumBits(NumBits), .DenBits(9), .TagBits($bits(side_t))) u_div_p (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .num_i(pnum), .den_i(pden),
    .tag_i(side_d), .valid_o(pv), .quot_o(pq), .tag_o(side_div)
  );
  uvs_divider #(.NumBits(NumBits), .DenBits(9), .TagBits(1)) u_div_a (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .num_i(anum), .den_i(aden),
    .tag_i(1'b0), .valid_o(av), .quot_o(aq), .tag_o(av_tag)
  );

  logic signed [31:0] cp, sp, ca, sa;
  uvs_cordic #(.AngleBits(ANGLE_BITS)) u_cor_p (
    .clk_i, .en_i(en), .angle_i(pq[ANGLE_BITS-1:0]), .cos_o(cp), .sin_o(sp)
  );
  uvs_cordic #(.AngleBits(ANGLE_BITS)) u_cor_a (
    .clk_i, .en_i(en), .angle_i(aq[ANGLE_BITS-1:0]), .cos_o(ca), .sin_o(sa)
  );

  // Side data and valid follow the CORDIC latency.
  logic            vsh_q [CorLat+1];
  side_t           ssh_q [CorLat+1];
  always_comb begin
    vsh_q[0] = pv;
    ssh_q[0] = side_t'(side_div);
  end
  for (genvar k = 0; k < CorLat; k++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vsh_q[k+1] <= 1'b0;
      else if (en) vsh_q[k+1] <= vsh_q[k];
    end
    always_ff @(posedge clk_i) begin
      if (en) ssh_q[k+1] <= ssh_q[k];
    end
  end

  // Scale stage 1: R*cos_p and R*sin_p.
  logic signed [48:0] ry_q, rr_q;
  logic signed [31:0] ca_q, sa_q;
  logic               v1_q;
  side_t              s1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ry_q <= 49'($signed({1'b0, ssh_q[CorLat].radius})) * 49'(cp);
      rr_q <= 49'($signed({1'b0, ssh_q[CorLat].radius})) * 49'(sp);
      ca_q <= ca;
      sa_q <= sa;
      s1_q <= ssh_q[CorLat];
    end
  end

  // Scale stage 2: round y and the ring radius.
  function automatic logic signed [16:0] sat17(input logic signed [63:0] v);
    logic signed [16:0] r;
    if (v > 64'sd65535) r = 17'sd65535;
    else if (v < -64'sd65535) r = -17'sd65535;
    else r = 17'(v);
    return r;
  endfunction

  logic signed [16:0] y2_q;
  logic signed [34:0] ring_q;
  logic signed [31:0] ca2_q, sa2_q;
  logic               v2_q;
  side_t              s2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      y2_q   <= sat17(64'((ry_q + 49'sd536870912) >>> 30));
      ring_q <= 35'((rr_q + 49'sd8192) >>> 14);
      ca2_q  <= ca_q;
      sa2_q  <= sa_q;
      s2_q   <= s1_q;
    end
  end

  // Scale stage 3: ring times azimuth cos and sin.
  logic signed [66:0] xp_q, zp_q;
  logic signed [16:0] y3_q;
  logic               v3_q;
  side_t              s3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      xp_q <= 67'(ring_q) * 67'(ca2_q);
      zp_q <= 67'(ring_q) * 67'(sa2_q);
      y3_q <= y2_q;
      s3_q <= s2_q;
    end
  end

  logic signed [66:0] half46;
  assign half46 = 67'sd1 <<< 45;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      v1_q <= vsh_q[CorLat];
      v2_q <= v1_q;
      v3_q <= v2_q;
      out_valid_o <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (s3_q.err) begin
        coord_x_o <= '0;
        coord_y_o <= '0;
        coord_z_o <= '0;
      end else begin
        coord_x_o <= sat17(64'((xp_q + half46) >>> 46));
        coord_y_o <= y3_q;
        coord_z_o <= sat17(64'((zp_q + half46) >>> 46));
      end
      range_error_o  <= s3_q.err;
      quad_valid_o   <= s3_q.quad;
      tri_a_first_o  <= s3_q.quad ? s3_q.f : '0;
      tri_a_second_o <= s3_q.quad ? s3_q.s : '0;
      tri_a_third_o  <= s3_q.quad ? 16'(s3_q.f + 16'd1) : '0;
      tri_b_first_o  <= s3_q.quad ? s3_q.s : '0;
      tri_b_second_o <= s3_q.quad ? 16'(s3_q.s + 16'd1) : '0;
      tri_b_third_o  <= s3_q.quad ? 16'(s3_q.f + 16'd1) : '0;
    end
  end

  `UVS_ASSERT(a_div_lockstep, pv == av, "angle dividers out of step")
  `UVS_ASSERT(a_err_quad, !(out_valid_o && range_error_o && quad_valid_o), "error with quad")
  `UVS_ASSERT_NEXT(a_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")
  `UVS_ASSERT(a_tag_zero, !av || !av_tag, "azimuth tag corrupt")
endmodule

[design/uvs_divider.sv]
// Pipelined restoring divider: quotient of num by den, one bit per stage.
// Depends on uvs_pkg; used by the top level for the angle fractions.
module uvs_divider import uvs_pkg::*; #(
  parameter int NumBits = 26,
  parameter int DenBits = 9,
  parameter int TagBits = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [NumBits-1:0] num_i,
  input  logic [DenBits-1:0] den_i,
  input  logic [TagBits-1:0] tag_i,
  output logic               valid_o,
  output logic [NumBits-1:0] quot_o,
  output logic [TagBits-1:0] tag_o
);
  logic               vld_q [NumBits+1];
  logic [NumBits-1:0] num_q [NumBits+1];
  logic [DenBits:0]   rem_q [NumBits+1];
  logic [DenBits-1:0] den_q [NumBits+1];
  logic [TagBits-1:0] tag_q [NumBits+1];

  always_comb begin
    num_q[0] = num_i;
    rem_q[0] = '0;
    den_q[0] = den_i;
    tag_q[0] = tag_i;
    vld_q[0] = valid_i;
  end

  for (genvar k = 0; k < NumBits; k++) begin : g_stage
    logic [DenBits+1:0] trial;
    logic [DenBits:0]   rem_d;
    logic [NumBits-1:0] num_d;
    always_comb begin
      trial = {rem_q[k], num_q[k][NumBits-1]};
      num_d = {num_q[k][NumBits-2:0], 1'b0};
      if (trial >= {2'b00, den_q[k]}) begin
        rem_d = (DenBits+1)'(trial - {2'b00, den_q[k]});
        num_d[0] = 1'b1;
      end else begin
        rem_d = trial[DenBits:0];
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k+1] <= num_d;
        rem_q[k+1] <= rem_d;
        den_q[k+1] <= den_q[k];
        tag_q[k+1] <= tag_q[k];
      end
    end
  end

  assign valid_o = vld_q[NumBits];
  assign quot_o  = num_q[NumBits];
  assign tag_o   = tag_q[NumBits];
endmodule

[design/uvs_cordic.sv]
// Pipelined rotation CORDIC giving clamped Q2.30 cos and sin of a turn fraction.
// Depends on uvs_pkg; used by the top level for both angles.
module uvs_cordic import uvs_pkg::*; #(
  parameter int AngleBits = AngleBitsDef
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [AngleBits-1:0] angle_i,
  output logic signed [31:0]   cos_o,
  output logic signed [31:0]   sin_o
);
  logic signed [33:0] x_q [CordicSteps+1];
  logic signed [33:0] y_q [CordicSteps+1];
  logic signed [33:0] z_q [CordicSteps+1];
  logic [1:0]         qd_q [CordicSteps+1];
  logic [31:0]        a32;

  assign a32 = {angle_i, {(32-AngleBits){1'b0}}};
  always_comb begin
    x_q[0]  = CordicInit;
    y_q[0]  = '0;
    z_q[0]  = {4'b0000, a32[29:0]};
    qd_q[0] = a32[31:30];
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        qd_q[i+1] <= qd_q[i];
        if (!z_q[i][33]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_turn(i);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_turn(i);
        end
      end
    end
  end

  logic signed [33:0] c, s;
  localparam logic signed [33:0] One = 34'sd1073741824;
  always_comb begin
    case (qd_q[CordicSteps])
      2'd0: begin c = x_q[CordicSteps];  s = y_q[CordicSteps];  end
      2'd1: begin c = -y_q[CordicSteps]; s = x_q[CordicSteps];  end
      2'd2: begin c = -x_q[CordicSteps]; s = -y_q[CordicSteps]; end
      default: begin c = y_q[CordicSteps]; s = -x_q[CordicSteps]; end
    endcase
    if (c > One) c = One;
    if (c < -One) c = -One;
    if (s > One) s = One;
    if (s < -One) s = -One;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_o <= 32'(c);
      sin_o <= 32'(s);
    end
  end
endmodule

[bench/tb.sv]
// Self-checking testbench for the UV sphere vertex generator.
// Drives grid positions through a queue-fed driver, predicts each vertex and
// its quad indices, and compares results in a clocked monitor. Needs uvs_pkg.
`timescale 1ns / 100ps

module tb;
  import uvs_pkg::*;

  typedef struct packed {
    logic [16:0] x;
    logic [16:0] y;
    logic [16:0] z;
    logic        quad;
    logic [15:0] a0;
    logic [15:0] a1;
    logic [15:0] a2;
    logic [15:0] b0;
    logic [15:0] b1;
    logic [15:0] b2;
    logic        err;
  } vertex_t;

  typedef struct packed {
    logic [7:0] st;
    logic [7:0] sl;
  } pos_t;

  localparam longint AtanTab [28] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
  };
  localparam int WatchLimit = 3000;
  localparam int HoldLen = 400;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [7:0] stack_pos_i, slice_pos_i;
  logic signed [16:0] coord_x_o, coord_y_o, coord_z_o;
  logic quad_valid_o, range_error_o;
  logic [15:0] tri_a_first_o, tri_a_second_o, tri_a_third_o;
  logic [15:0] tri_b_first_o, tri_b_second_o, tri_b_third_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [15:0] cfg_data_i;

  uv_sphere_vertex_generator DUT (.*);

  pos_t    pending_pos[$];
  vertex_t vertex_q[$];
  logic [15:0] radius_r;
  logic [7:0]  slices_r, stacks_r;
  int errors, mismatches, idle_cycles;
  bit calm;
  int hold_reqs, hold_done, hold_cnt, out_gap, in_gap;
  bit in_fire;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint rshift_round(longint v, int k);
    return (v + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

  function automatic longint sat(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic void rotate_angle(input logic [15:0] ang, output longint c,
                                       output longint s);
    logic [31:0] a32;
    longint x, y, z, dx, dy;
    a32 = {ang, 16'h0};
    x = 652032874;
    y = 0;
    z = longint'(a32[29:0]);
    for (int i = 0; i < 28; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanTab[i];
      end else begin
        x += dx; y -= dy; z += AtanTab[i];
      end
    end
    case (a32[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    c = sat(c, 64'sd1 <<< 30);
    s = sat(s, 64'sd1 <<< 30);
  endfunction

  function automatic vertex_t sphere_vertex(pos_t p);
    vertex_t v;
    longint st, sl, ns, nl, pa, aa, cp, sp, ca, sa, ring, f, s;
    v = '0;
    st = p.st; sl = p.sl; ns = stacks_r; nl = slices_r;
    if (ns == 0 || nl == 0 || st > ns || sl > nl) begin
      v.err = 1'b1;
      return v;
    end
    pa = ((st << 16) + ns) / (2 * ns);
    aa = (((sl << 17) + nl) / (2 * nl)) & 64'hFFFF;
    rotate_angle(pa[15:0], cp, sp);
    rotate_angle(aa[15:0], ca, sa);
    ring = rshift_round(longint'(radius_r) * sp, 14);
    v.y = 17'(sat(rshift_round(longint'(radius_r) * cp, 30), CoordLimit));
    v.x = 17'(sat(rshift_round(ring * ca, 46), CoordLimit));
    v.z = 17'(sat(rshift_round(ring * sa, 46), CoordLimit));
    if (st < ns && sl < nl) begin
      f = st * (nl + 1) + sl;
      s = f + nl + 1;
      v.quad = 1'b1;
      v.a0 = f[15:0]; v.a1 = s[15:0]; v.a2 = 16'(f + 1);
      v.b0 = s[15:0]; v.b1 = 16'(s + 1); v.b2 = 16'(f + 1);
    end
    return v;
  endfunction

  always @(posedge clk_i) begin
    vertex_t got, want;
    in_fire <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (in_valid_i && in_ready_o)
        vertex_q = {vertex_q, sphere_vertex(pos_t'{stack_pos_i, slice_pos_i})};
      if (out_valid_o && out_ready_i) begin
        got = '{coord_x_o, coord_y_o, coord_z_o, quad_valid_o, tri_a_first_o,
                tri_a_second_o, tri_a_third_o, tri_b_first_o, tri_b_second_o,
                tri_b_third_o, range_error_o};
        if (vertex_q.size() == 0) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result item: %h", got);
        end else begin
          want = vertex_q.pop_front();
          if (got !== want) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected %h, actual %h", want, got);
          end
        end
      end
      if (idle_cycles >= WatchLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    pos_t p;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_fire) begin
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      in_valid_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      in_gap <= $urandom_range(0, 12);
      in_valid_i <= 1'b0;
    end else if (pending_pos.size() > 0) begin
      p = pending_pos.pop_front();
      stack_pos_i <= p.st;
      slice_pos_i <= p.sl;
      in_valid_i <= 1'b1;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else if (hold_reqs != hold_done) begin
      hold_done <= hold_done + 1;
      hold_cnt <= HoldLen;
      out_ready_i <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_gap <= $urandom_range(0, 12);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgRadius: radius_r = data;
      CfgSlices: slices_r = data[7:0];
      CfgStacks: stacks_r = data[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_sphere(input logic [15:0] r, input logic [7:0] nl, input logic [7:0] ns);
    write_reg(CfgRadius, r);
    write_reg(CfgSlices, {8'($urandom), nl});
    write_reg(CfgStacks, {8'($urandom), ns});
  endtask

  task automatic queue_random(input int n);
    pos_t p;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 85) begin
        p.st = 8'($urandom_range(0, stacks_r));
        p.sl = 8'($urandom_range(0, slices_r));
      end else begin
        p.st = 8'($urandom);
        p.sl = 8'($urandom);
      end
      pending_pos = {pending_pos, p};
    end
  endtask

  task automatic drain();
    while (pending_pos.size() > 0 || in_valid_i || vertex_q.size() > 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  initial begin
    pos_t corners[$];
    errors = 0; mismatches = 0; idle_cycles = 0; calm = 0;
    hold_reqs = 0; hold_done = 0; hold_cnt = 0; out_gap = 0; in_gap = 0;
    in_fire = 0; in_valid_i = 0; out_ready_i = 0; stack_pos_i = 0; slice_pos_i = 0;
    cfg_valid_i = 0; cfg_index_i = CfgRadius; cfg_data_i = 0;
    radius_r = 256; slices_r = 16; stacks_r = 16;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    corners = '{'{0, 0}, '{16, 16}, '{16, 0}, '{0, 16}, '{15, 15}, '{8, 0},
                '{8, 4}, '{8, 8}, '{8, 12}, '{4, 2}, '{12, 14}, '{17, 0},
                '{0, 17}, '{255, 255}, '{128, 3}, '{3, 128}, '{15, 16}, '{16, 15},
                '{1, 1}, '{170, 85}};
    foreach (corners[i]) pending_pos = {pending_pos, corners[i]};
    drain();

    set_sphere(16'hFFFF, 8'd255, 8'd255);
    queue_random(300);
    hold_reqs = 1;
    drain();

    set_sphere(16'h0000, 8'd1, 8'd1);
    queue_random(100);
    drain();

    set_sphere(16'd1, 8'd7, 8'd0);
    queue_random(50);
    drain();
    set_sphere(16'd300, 8'd0, 8'd5);
    queue_random(50);
    drain();

    for (int k = 0; k < 6; k++) begin
      set_sphere(16'($urandom), 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
      if (k == 5) calm = 1;
      queue_random(190);
      drain();
    end

    if (vertex_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
